/* rtl/core/i2p_pkg.sv */
package i2p_pkg;

  typedef logic [2:0] code_t;
  typedef logic [1:0] kind_t;
  typedef logic [1:0] prec_t;
  typedef logic [1:0] status_t;

  localparam code_t CODE_OPEN = 3'd0;
  localparam code_t CODE_ADD  = 3'd1;
  localparam code_t CODE_SUB  = 3'd2;
  localparam code_t CODE_MUL  = 3'd3;
  localparam code_t CODE_DIV  = 3'd4;

  localparam kind_t KIND_CLOSE = 2'd0;
  localparam kind_t KIND_OP    = 2'd1;
  localparam kind_t KIND_END   = 2'd2;

  localparam status_t ST_OK       = 2'd0;
  localparam status_t ST_OVERFLOW = 2'd1;
  localparam status_t ST_CLOSE    = 2'd2;
  localparam status_t ST_OPEN     = 2'd3;

  localparam logic [7:0] CH_OPEN  = 8'h28;
  localparam logic [7:0] CH_CLOSE = 8'h29;
  localparam logic [7:0] CH_MUL   = 8'h2a;
  localparam logic [7:0] CH_ADD   = 8'h2b;
  localparam logic [7:0] CH_SUB   = 8'h2d;
  localparam logic [7:0] CH_DIV   = 8'h2f;
  localparam logic [7:0] CH_NUL   = 8'h00;

  function automatic logic is_alnum(input logic [7:0] c);
    return c inside {[8'h30:8'h39], [8'h41:8'h5a], [8'h61:8'h7a]};
  endfunction

  function automatic logic is_op(input logic [7:0] c);
    return c inside {CH_ADD, CH_SUB, CH_MUL, CH_DIV};
  endfunction

  function automatic code_t op_code(input logic [7:0] c);
    case (c)
      CH_ADD:  return CODE_ADD;
      CH_SUB:  return CODE_SUB;
      CH_MUL:  return CODE_MUL;
      CH_DIV:  return CODE_DIV;
      default: return CODE_OPEN;
    endcase
  endfunction

  function automatic logic [7:0] code_char(input code_t t);
    case (t)
      CODE_OPEN: return CH_OPEN;
      CODE_ADD:  return CH_ADD;
      CODE_SUB:  return CH_SUB;
      CODE_MUL:  return CH_MUL;
      CODE_DIV:  return CH_DIV;
      default:   return CH_NUL;
    endcase
  endfunction

  function automatic prec_t code_prec(input code_t t);
    case (t)
      CODE_ADD, CODE_SUB: return 2'd1;
      CODE_MUL, CODE_DIV: return 2'd2;
      default:            return 2'd0;
    endcase
  endfunction

endpackage

/* rtl/core/i2p_stack.sv */
module i2p_stack
  import i2p_pkg::*;
#(
  parameter int DEPTH = 32,
  parameter int AW    = 5
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  code_t         wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output code_t         rd_data
);

  code_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* rtl/core/infix_to_postfix_converter_core.sv */
// A letter or digit is first registered as a pending result, then sent to the output;
// ')', an operator or the zero byte examine the stack one entry at a time, as the
// stack memory read is registered. Results stall while out_ready is low.
// A new byte is taken only while idle: ignored bytes are taken every cycle, but any
// other byte is finished, its results sent to the output, before the next is taken.
// Reset (synchronous, active high) empties the stack; stack contents are not cleared.
module infix_to_postfix_converter_core
  import i2p_pkg::*;
#(
  parameter int STACK_DEPTH = 32
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] symbol,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_symbol,
  output status_t    status,
  output logic       last
);

  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(STACK_DEPTH);
  localparam logic [CW-1:0] CNT_ONE  = CW'(1);
  localparam logic [CW-1:0] CNT_TWO  = CW'(2);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_TEST = 2'd1;
  localparam logic [1:0] S_FIN  = 2'd2;

  logic [1:0]    state;
  logic [CW-1:0] cnt;
  logic [7:0]    sym;
  kind_t         kind;
  code_t         op;
  logic          hold_v;
  logic [7:0]    hold_sym;
  status_t       hold_st;

  logic          accept;
  logic          out_free;
  logic          out_load;
  code_t         top;
  logic          new_v;
  logic [7:0]    new_sym;
  status_t       new_st;
  logic          pop;
  logic          push;
  logic          done;
  logic          step;
  logic          rd_en;
  logic [CW-1:0] rd_cnt;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  code_t         wr_data;
  logic          open_push;

  assign in_ready  = (state == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign out_free  = !out_valid || out_ready;
  assign open_push = accept && (symbol == CH_OPEN) && (cnt < CNT_FULL);
  assign out_load  = (step && new_v && hold_v) || ((state == S_FIN) && hold_v && out_free);

  i2p_stack #(.DEPTH(STACK_DEPTH), .AW(AW)) u_stack (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_cnt[AW-1:0]),
    .rd_data (top)
  );

  always_comb begin
    new_v   = 1'b0;
    new_sym = CH_NUL;
    new_st  = ST_OK;
    pop     = 1'b0;
    push    = 1'b0;
    done    = 1'b0;
    case (kind)
      KIND_CLOSE: begin
        if (cnt == '0) begin
          new_v   = 1'b1;
          new_sym = CH_CLOSE;
          new_st  = ST_CLOSE;
          done    = 1'b1;
        end else if (top == CODE_OPEN) begin
          pop  = 1'b1;
          done = 1'b1;
        end else begin
          new_v   = 1'b1;
          new_sym = code_char(top);
          pop     = 1'b1;
        end
      end
      KIND_OP: begin
        if ((cnt != '0) && (code_prec(top) >= code_prec(op))) begin
          new_v   = 1'b1;
          new_sym = code_char(top);
          pop     = 1'b1;
        end else if (cnt < CNT_FULL) begin
          push = 1'b1;
          done = 1'b1;
        end else begin
          new_v   = 1'b1;
          new_sym = sym;
          new_st  = ST_OVERFLOW;
          done    = 1'b1;
        end
      end
      KIND_END: begin
        new_v = 1'b1;
        if (cnt == '0) begin
          done = 1'b1;
        end else begin
          new_sym = code_char(top);
          new_st  = (top == CODE_OPEN) ? ST_OPEN : ST_OK;
          pop     = 1'b1;
        end
      end
      default: begin
        done = 1'b1;
      end
    endcase
    step = (state == S_TEST) && !(new_v && hold_v && !out_free);
  end

  always_comb begin
    rd_en   = accept || (step && pop);
    rd_cnt  = accept ? (cnt - CNT_ONE) : (cnt - CNT_TWO);
    wr_en   = open_push || (step && push);
    wr_addr = cnt[AW-1:0];
    wr_data = open_push ? CODE_OPEN : op;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      hold_v    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && !out_load) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            if (is_alnum(symbol)) begin
              hold_v   <= 1'b1;
              hold_sym <= symbol;
              hold_st  <= ST_OK;
              state    <= S_FIN;
            end else if (symbol == CH_OPEN) begin
              if (cnt < CNT_FULL) begin
                cnt <= cnt + CNT_ONE;
              end else begin
                hold_v   <= 1'b1;
                hold_sym <= symbol;
                hold_st  <= ST_OVERFLOW;
              end
              state <= S_FIN;
            end else if (symbol == CH_CLOSE) begin
              kind  <= KIND_CLOSE;
              state <= S_TEST;
            end else if (is_op(symbol)) begin
              kind  <= KIND_OP;
              op    <= op_code(symbol);
              sym   <= symbol;
              state <= S_TEST;
            end else if (symbol == CH_NUL) begin
              kind  <= KIND_END;
              state <= S_TEST;
            end
          end
        end
        S_TEST: begin
          if (step) begin
            if (new_v) begin
              if (hold_v) begin
                out_valid  <= 1'b1;
                out_symbol <= hold_sym;
                status     <= hold_st;
                last       <= 1'b0;
              end
              hold_v   <= 1'b1;
              hold_sym <= new_sym;
              hold_st  <= new_st;
            end
            if (pop) begin
              cnt <= cnt - CNT_ONE;
            end else if (push) begin
              cnt <= cnt + CNT_ONE;
            end
            if (done) begin
              state <= S_FIN;
            end
          end
        end
        S_FIN: begin
          if (!hold_v) begin
            state <= S_IDLE;
          end else if (out_free) begin
            out_valid  <= 1'b1;
            out_symbol <= hold_sym;
            status     <= hold_st;
            last       <= 1'b1;
            hold_v     <= 1'b0;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst) cnt <= CNT_FULL)
    else $error("stack count beyond depth");

  a_idle_empty: assert property (@(posedge clk) disable iff (rst) in_ready |-> !hold_v)
    else $error("pending result left when taking a new beat");

  a_open_push: assert property (@(posedge clk) disable iff (rst)
    open_push |=> cnt == $past(cnt) + CNT_ONE)
    else $error("open paren push lost");

  a_pop_read: assert property (@(posedge clk) disable iff (rst)
    (step && pop && !done) |=> state == S_TEST && cnt == $past(cnt) - CNT_ONE)
    else $error("pop did not advance to next stack entry");

endmodule
